>>> rtl/btlrb_pkg.sv
`default_nettype none

package btlrb_pkg;

  typedef struct packed {
    logic        button_pressed;
    logic        range_valid;
    logic [12:0] range_mm;
  } in_item_t;

  typedef struct packed {
    logic red_on;
    logic yellow_on;
    logic green_on;
    logic range_mode;
  } out_item_t;

  typedef struct packed {
    logic [15:0] long_press_ticks;
    logic [15:0] start_delay_ticks;
    logic [15:0] green_ticks;
    logic [15:0] yellow_ticks;
    logic [15:0] blink_ticks;
    logic [12:0] far_mm;
    logic [12:0] mid_mm;
    logic [12:0] near_mm;
  } cfg_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_PRESS  = 4'd1,
    PH_START  = 4'd2,
    PH_GREEN  = 4'd3,
    PH_YELLOW = 4'd4,
    PH_HOLD   = 4'd5,
    PH_RANGE  = 4'd6,
    PH_EXIT   = 4'd7
  } phase_t;

  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YELLOW      = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK       = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAR         = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MID         = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR        = 8'd7;

  localparam logic [15:0] RST_LONG_PRESS  = 16'd2000;
  localparam logic [15:0] RST_START_DELAY = 16'd3000;
  localparam logic [15:0] RST_GREEN       = 16'd10000;
  localparam logic [15:0] RST_YELLOW      = 16'd2000;
  localparam logic [15:0] RST_BLINK       = 16'd500;
  localparam logic [12:0] RST_FAR         = 13'd180;
  localparam logic [12:0] RST_MID         = 13'd120;
  localparam logic [12:0] RST_NEAR        = 13'd80;

  // lamp vector: bit 0 red, bit 1 yellow, bit 2 green
  localparam logic [2:0] LAMP_OFF    = 3'b000;
  localparam logic [2:0] LAMP_RED    = 3'b001;
  localparam logic [2:0] LAMP_YELLOW = 3'b010;
  localparam logic [2:0] LAMP_GREEN  = 3'b100;
  localparam logic [2:0] LAMP_GY     = 3'b110;
  localparam logic [2:0] LAMP_ALL    = 3'b111;

endpackage

`default_nettype wire

>>> rtl/btlrb_cfg.sv
`default_nettype none

module btlrb_cfg
  import btlrb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [15:0]          wr_data,
  output cfg_t                      cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ticks  <= RST_LONG_PRESS;
      cfg_r.start_delay_ticks <= RST_START_DELAY;
      cfg_r.green_ticks       <= RST_GREEN;
      cfg_r.yellow_ticks      <= RST_YELLOW;
      cfg_r.blink_ticks       <= RST_BLINK;
      cfg_r.far_mm            <= RST_FAR;
      cfg_r.mid_mm            <= RST_MID;
      cfg_r.near_mm           <= RST_NEAR;
    end else if (wr_en) begin
      case (wr_index)
        REG_LONG_PRESS:  cfg_r.long_press_ticks  <= wr_data;
        REG_START_DELAY: cfg_r.start_delay_ticks <= wr_data;
        REG_GREEN:       cfg_r.green_ticks       <= wr_data;
        REG_YELLOW:      cfg_r.yellow_ticks      <= wr_data;
        REG_BLINK:       cfg_r.blink_ticks       <= wr_data;
        REG_FAR:         cfg_r.far_mm            <= wr_data[12:0];
        REG_MID:         cfg_r.mid_mm            <= wr_data[12:0];
        REG_NEAR:        cfg_r.near_mm           <= wr_data[12:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/btlrb_core.sv
`default_nettype none

module btlrb_core
  import btlrb_pkg::*;
#(
  parameter int unsigned DEBOUNCE_TICKS = 50
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output out_item_t     result
);

  localparam logic [15:0] DEBOUNCE = 16'(DEBOUNCE_TICKS);

  phase_t      phase_r, phase_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [2:0]  lamps_r, lamps_nxt;
  logic        blink_r, blink_nxt;

  logic [15:0] timer_inc;
  logic        btn;
  logic [12:0] r;

  assign btn       = item.button_pressed;
  assign r         = item.range_mm;
  assign timer_inc = (timer_r == 16'hFFFF) ? timer_r : timer_r + 16'd1;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: if (btn) phase_nxt = PH_PRESS;
      PH_PRESS: begin
        if (timer_inc >= DEBOUNCE) begin
          if (!btn) phase_nxt = PH_START;
          else if (timer_inc >= cfg.long_press_ticks) phase_nxt = PH_HOLD;
        end
      end
      PH_START:  if (timer_inc >= cfg.start_delay_ticks) phase_nxt = PH_GREEN;
      PH_GREEN:  if (timer_inc >= cfg.green_ticks) phase_nxt = PH_YELLOW;
      PH_YELLOW: if (timer_inc >= cfg.yellow_ticks) phase_nxt = PH_IDLE;
      PH_HOLD:   if (!btn) phase_nxt = PH_RANGE;
      PH_RANGE:  if (btn) phase_nxt = PH_EXIT;
      PH_EXIT:   if (timer_inc >= DEBOUNCE && !btn) phase_nxt = PH_IDLE;
      default:   phase_nxt = PH_IDLE;
    endcase
  end

  // timer, lamps and blink level
  always_comb begin
    timer_nxt = timer_r;
    lamps_nxt = lamps_r;
    blink_nxt = blink_r;
    case (phase_r)
      PH_IDLE: begin
        lamps_nxt = LAMP_RED;
        if (btn) timer_nxt = 16'd0;
      end
      PH_PRESS: begin
        timer_nxt = timer_inc;
        if (timer_inc >= DEBOUNCE) begin
          if (!btn) begin
            timer_nxt = 16'd0;
            lamps_nxt = LAMP_RED;
          end else if (timer_inc >= cfg.long_press_ticks) begin
            timer_nxt = 16'd0;
            lamps_nxt = LAMP_ALL;
            blink_nxt = 1'b1;
          end
        end
      end
      PH_START: begin
        timer_nxt = timer_inc;
        if (timer_inc >= cfg.start_delay_ticks) begin
          timer_nxt = 16'd0;
          lamps_nxt = LAMP_GREEN;
        end
      end
      PH_GREEN: begin
        timer_nxt = timer_inc;
        if (timer_inc >= cfg.green_ticks) begin
          timer_nxt = 16'd0;
          lamps_nxt = LAMP_YELLOW;
        end
      end
      PH_YELLOW: begin
        timer_nxt = timer_inc;
        if (timer_inc >= cfg.yellow_ticks) begin
          timer_nxt = 16'd0;
          lamps_nxt = LAMP_RED;
        end
      end
      PH_HOLD: begin
        if (!btn) begin
          timer_nxt = 16'd0;
        end else begin
          timer_nxt = timer_inc;
          if (timer_inc >= cfg.blink_ticks) begin
            timer_nxt = 16'd0;
            blink_nxt = ~blink_r;
            lamps_nxt = blink_r ? LAMP_OFF : LAMP_ALL;
          end
        end
      end
      PH_RANGE: begin
        if (btn) begin
          timer_nxt = 16'd0;
        end else if (item.range_valid) begin
          // out-of-order thresholds or a sample equal to far can leave the lamps unchanged
          if (r > cfg.far_mm) lamps_nxt = LAMP_OFF;
          else if (r < cfg.far_mm && r >= cfg.mid_mm) lamps_nxt = LAMP_GREEN;
          else if (r < cfg.mid_mm && r >= cfg.near_mm) lamps_nxt = LAMP_GY;
          else if (r < cfg.near_mm) lamps_nxt = LAMP_ALL;
        end
      end
      PH_EXIT: begin
        timer_nxt = timer_inc;
        if (timer_inc >= DEBOUNCE && !btn) begin
          timer_nxt = 16'd0;
          lamps_nxt = LAMP_RED;
        end
      end
      default: begin
        timer_nxt = 16'd0;
        lamps_nxt = LAMP_RED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= 16'd0;
      lamps_r <= LAMP_RED;
      blink_r <= 1'b1;
    end else if (step) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      lamps_r <= lamps_nxt;
      blink_r <= blink_nxt;
    end
  end

  assign result.red_on     = lamps_nxt[0];
  assign result.yellow_on  = lamps_nxt[1];
  assign result.green_on   = lamps_nxt[2];
  assign result.range_mode = (phase_nxt == PH_HOLD) || (phase_nxt == PH_RANGE) ||
                             (phase_nxt == PH_EXIT);

endmodule

`default_nettype wire

>>> rtl/button_traffic_light_with_range_bar_unit.sv
`default_nettype none

// channel   direction  handshake              payload
// in_       input      in_valid / in_stall    in_item_t  (one tick)
// out_      output     out_valid / out_stall  out_item_t (lamps after the tick)
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one tick is taken every cycle while in_stall is low; its result passes the input register,
// the phase logic and the result register before it is offered on out_.
// reset (rst_n low, synchronous) puts the lights on red idle and reloads the
// register defaults; a stalled result holds the pipe, and in_stall rises only
// while both the input register and the result register are occupied and stalled.

module button_traffic_light_with_range_bar_unit
  import btlrb_pkg::*;
#(
  parameter int unsigned DEBOUNCE_TICKS = 50
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_valid_r;
  out_item_t out_item_r;
  logic      out_valid_r;
  out_item_t result;
  logic      out_free;
  logic      step;

  assign cfg_ready = 1'b1;

  btlrb_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_data;
    end
  end

  btlrb_core #(
    .DEBOUNCE_TICKS (DEBOUNCE_TICKS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire

>>> test/tb_button_traffic_light_with_range_bar_unit.sv
`default_nettype none

module tb_button_traffic_light_with_range_bar_unit;
  import btlrb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEBOUNCE_TICKS = 50;
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned PHASE_TICKS = 90;
  localparam int unsigned MAX_PRINTED = 50;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 8'hFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  button_traffic_light_with_range_bar_unit #(
    .DEBOUNCE_TICKS(DEBOUNCE_TICKS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // light controller state as predicted
  phase_t ph = PH_IDLE;
  int unsigned ph_timer = 0;
  logic [2:0] lamp_q = LAMP_RED;
  logic blink_on = 1'b1;
  cfg_t regs = '{RST_LONG_PRESS, RST_START_DELAY, RST_GREEN, RST_YELLOW, RST_BLINK,
                 RST_FAR, RST_MID, RST_NEAR};

  out_item_t lamp_queue[$];
  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  bit no_idling = 1'b0;
  bit hold_off_req = 1'b0;

  function automatic int unsigned sat_inc(int unsigned v);
    return (v >= 32'hFFFF) ? 32'hFFFF : v + 1;
  endfunction

  function automatic void enter_phase(phase_t p, logic [2:0] l);
    ph = p;
    ph_timer = 0;
    lamp_q = l;
  endfunction

  function automatic out_item_t step_lamps(in_item_t t);
    out_item_t o;
    logic [12:0] r;
    r = t.range_mm;
    case (ph)
      PH_IDLE: begin
        lamp_q = LAMP_RED;
        if (t.button_pressed) enter_phase(PH_PRESS, LAMP_RED);
      end
      PH_PRESS: begin
        ph_timer = sat_inc(ph_timer);
        if (ph_timer >= DEBOUNCE_TICKS) begin
          if (!t.button_pressed) begin
            enter_phase(PH_START, LAMP_RED);
          end else if (ph_timer >= regs.long_press_ticks) begin
            blink_on = 1'b1;
            enter_phase(PH_HOLD, LAMP_ALL);
          end
        end
      end
      PH_START: begin
        ph_timer = sat_inc(ph_timer);
        if (ph_timer >= regs.start_delay_ticks) enter_phase(PH_GREEN, LAMP_GREEN);
      end
      PH_GREEN: begin
        ph_timer = sat_inc(ph_timer);
        if (ph_timer >= regs.green_ticks) enter_phase(PH_YELLOW, LAMP_YELLOW);
      end
      PH_YELLOW: begin
        ph_timer = sat_inc(ph_timer);
        if (ph_timer >= regs.yellow_ticks) enter_phase(PH_IDLE, LAMP_RED);
      end
      PH_HOLD: begin
        if (!t.button_pressed) begin
          enter_phase(PH_RANGE, lamp_q);
        end else begin
          ph_timer = sat_inc(ph_timer);
          if (ph_timer >= regs.blink_ticks) begin
            blink_on = ~blink_on;
            ph_timer = 0;
            lamp_q = blink_on ? LAMP_ALL : LAMP_OFF;
          end
        end
      end
      PH_RANGE: begin
        if (t.button_pressed) begin
          enter_phase(PH_EXIT, lamp_q);
        end else if (t.range_valid) begin
          // a sample equal to far, or thresholds out of order, can match nothing
          if (r > regs.far_mm) lamp_q = LAMP_OFF;
          else if (r < regs.far_mm && r >= regs.mid_mm) lamp_q = LAMP_GREEN;
          else if (r < regs.mid_mm && r >= regs.near_mm) lamp_q = LAMP_GY;
          else if (r < regs.near_mm) lamp_q = LAMP_ALL;
        end
      end
      PH_EXIT: begin
        ph_timer = sat_inc(ph_timer);
        if (ph_timer >= DEBOUNCE_TICKS && !t.button_pressed) enter_phase(PH_IDLE, LAMP_RED);
      end
      default: enter_phase(PH_IDLE, LAMP_RED);
    endcase
    o.red_on = lamp_q[0];
    o.yellow_on = lamp_q[1];
    o.green_on = lamp_q[2];
    o.range_mode = (ph == PH_HOLD || ph == PH_RANGE || ph == PH_EXIT);
    return o;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) lamp_queue.push_back(step_lamps(in_data));
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (lamp_queue.size() == 0) begin
        report_mismatch("result with no tick pending", 32'(out_data), 0);
      end else begin
        want = lamp_queue.pop_front();
        if (out_data.red_on !== want.red_on)
          report_mismatch("red_on", 32'(out_data.red_on), 32'(want.red_on));
        if (out_data.yellow_on !== want.yellow_on)
          report_mismatch("yellow_on", 32'(out_data.yellow_on), 32'(want.yellow_on));
        if (out_data.green_on !== want.green_on)
          report_mismatch("green_on", 32'(out_data.green_on), 32'(want.green_on));
        if (out_data.range_mode !== want.range_mode)
          report_mismatch("range_mode", 32'(out_data.range_mode), 32'(want.range_mode));
      end
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (!no_idling && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  function automatic in_item_t mk_tick(logic btn, logic vld, logic [12:0] mm);
    in_item_t t;
    t.button_pressed = btn;
    t.range_valid = vld;
    t.range_mm = mm;
    return t;
  endfunction

  // distances clustered around the current thresholds, or anywhere
  function automatic logic [12:0] pick_range();
    int r;
    r = $urandom_range(0, 8191);
    case ($urandom_range(0, 5))
      0: r = int'(regs.far_mm) + int'($urandom_range(0, 2)) - 1;
      1: r = int'(regs.mid_mm) + int'($urandom_range(0, 2)) - 1;
      2: r = int'(regs.near_mm) + int'($urandom_range(0, 2)) - 1;
      default: ;
    endcase
    if (r < 0) r = 0;
    if (r > 8191) r = 8191;
    return 13'(r);
  endfunction

  task automatic send_tick(in_item_t t);
    if (!no_idling && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic press_for(int unsigned n);
    repeat (n) send_tick(mk_tick(1'b1, 1'($urandom_range(0, 1)), pick_range()));
  endtask

  task automatic release_for(int unsigned n);
    repeat (n) send_tick(mk_tick(1'b0, 1'($urandom_range(0, 1)), pick_range()));
  endtask

  task automatic noise_for(int unsigned n);
    repeat (n)
      send_tick(mk_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_range()));
  endtask

  task automatic sample(logic [12:0] mm);
    send_tick(mk_tick(1'b0, 1'b1, mm));
  endtask

  // wait until every transaction is out before touching the registers
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lamp_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LONG_PRESS: regs.long_press_ticks = value;
      REG_START_DELAY: regs.start_delay_ticks = value;
      REG_GREEN: regs.green_ticks = value;
      REG_YELLOW: regs.yellow_ticks = value;
      REG_BLINK: regs.blink_ticks = value;
      REG_FAR: regs.far_mm = value[12:0];
      REG_MID: regs.mid_mm = value[12:0];
      REG_NEAR: regs.near_mm = value[12:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic randomize_regs();
    int unsigned lo;
    int unsigned md;
    int unsigned hi;
    write_reg(REG_LONG_PRESS, 16'($urandom_range(1, 120)));
    write_reg(REG_START_DELAY, 16'($urandom_range(0, 20)));
    write_reg(REG_GREEN, 16'($urandom_range(1, 25)));
    write_reg(REG_YELLOW, 16'($urandom_range(1, 25)));
    write_reg(REG_BLINK, 16'($urandom_range(1, 12)));
    if ($urandom_range(0, 4) != 0) begin
      lo = $urandom_range(0, 7900);
      md = lo + $urandom_range(0, 120);
      hi = md + $urandom_range(0, 120);
    end else begin
      lo = $urandom_range(0, 8191);
      md = $urandom_range(0, 8191);
      hi = $urandom_range(0, 8191);
    end
    write_reg(REG_FAR, 16'(hi));
    write_reg(REG_MID, 16'(md));
    write_reg(REG_NEAR, 16'(lo));
  endtask

  task automatic run_episodes(int unsigned n);
    int unsigned stop_at;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      case ($urandom_range(0, 3))
        0: press_for($urandom_range(1, 10));
        1: press_for($urandom_range(DEBOUNCE_TICKS - 5, DEBOUNCE_TICKS + 10));
        default: press_for($urandom_range(1, 160));
      endcase
      release_for($urandom_range(1, 70));
      if ($urandom_range(0, 7) == 0) noise_for($urandom_range(1, 6));
    end
  endtask

  // reset thresholds drive the bar; long press shorter than the debounce
  task automatic test_bar_at_reset_thresholds();
    logic [12:0] probes[10] = '{13'd181, 13'd180, 13'd179, 13'd120, 13'd119,
                                13'd80, 13'd79, 13'd0, 13'd180, 13'h1FFF};
    // samples outside range mode do nothing
    sample(13'h1FFF);
    sample(13'd0);
    release_for(2);
    settle();
    write_reg(REG_LONG_PRESS, 16'd1);
    press_for(DEBOUNCE_TICKS + 2);
    send_tick(mk_tick(1'b0, 1'b0, 13'd0));
    foreach (probes[i]) sample(probes[i]);
    // early release during exit is ignored
    press_for(3);
    release_for(5);
    press_for(DEBOUNCE_TICKS);
    release_for(3);
  endtask

  task automatic test_traffic_run();
    settle();
    write_reg(REG_LONG_PRESS, 16'hFFFF);
    write_reg(REG_START_DELAY, 16'd0);
    write_reg(REG_GREEN, 16'd1);
    write_reg(REG_YELLOW, 16'd1);
    write_reg(REG_NONE, 16'hFFFF);
    press_for(1);
    noise_for(DEBOUNCE_TICKS - 2);
    release_for(2);
    // presses during the run are ignored
    press_for(3);
    release_for(3);
    // a hold under the long-press time is still a short press
    press_for(80);
    release_for(8);
  endtask

  task automatic test_blink_and_odd_thresholds();
    settle();
    write_reg(REG_LONG_PRESS, 16'd60);
    write_reg(REG_BLINK, 16'd1);
    press_for(75);
    release_for(1);
    settle();
    write_reg(REG_FAR, 16'hFFFF);
    write_reg(REG_MID, 16'd0);
    write_reg(REG_NEAR, 16'd0);
    sample(13'h1FFF);
    sample(13'd0);
    sample(13'd4000);
    settle();
    write_reg(REG_FAR, 16'd0);
    write_reg(REG_MID, 16'h1FFF);
    write_reg(REG_NEAR, 16'h1FFF);
    sample(13'd0);
    sample(13'd1);
    sample(13'h1FFF);
    press_for(DEBOUNCE_TICKS + 1);
    release_for(2);
    settle();
    write_reg(REG_BLINK, 16'hFFFF);
    write_reg(REG_LONG_PRESS, 16'd1);
    press_for(70);
    release_for(4);
    press_for(DEBOUNCE_TICKS);
    release_for(2);
  endtask

  task automatic test_backpressure();
    settle();
    randomize_regs();
    hold_off_req = 1'b1;
    run_episodes(150);
  endtask

  task automatic test_random_phase(bit last);
    settle();
    randomize_regs();
    no_idling = last;
    run_episodes(PHASE_TICKS);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_bar_at_reset_thresholds();
    test_traffic_run();
    test_blink_and_odd_thresholds();
    test_backpressure();
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) test_random_phase(p == RANDOM_PHASES - 1);
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_button_traffic_light_with_range_bar_unit: PASS");
    end else begin
      $display("tb_button_traffic_light_with_range_bar_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_button_traffic_light_with_range_bar_unit: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

>>> button_traffic_light_with_range_bar_unit.f
rtl/btlrb_pkg.sv
rtl/btlrb_cfg.sv
rtl/btlrb_core.sv
rtl/button_traffic_light_with_range_bar_unit.sv
test/tb_button_traffic_light_with_range_bar_unit.sv
